FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the mean squared displacement block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst, expr, msg)
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

FILE: sv/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Types and fixed constants shared by the mean squared displacement modules.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int POS_W      = 32;
  localparam int BOX_W      = 31;
  localparam int MSD_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // restoring divider, one quotient bit per cycle
  localparam int DIV_STEPS = MSD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    OP_SNAPSHOT         = 2'd0,
    OP_MEASURE_SNAPSHOT = 2'd1,
    OP_MEASURE          = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRAP_ENABLE = 2'd0,
    REG_BOX_X       = 2'd1,
    REG_BOX_Y       = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MISMATCH    = 3'd1,
    ST_NO_SNAPSHOT = 3'd2,
    ST_CAPACITY    = 3'd3,
    ST_SATURATED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_RUN     = 2'd0,
    BK_DIVIDE  = 2'd1,
    BK_DELIVER = 2'd2
  } back_state_t;

  typedef struct packed {
    logic                 wrap_enable;
    logic [BOX_W-1:0]     box_x;
    logic [BOX_W-1:0]     box_y;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } coords_t;

  // per-particle classification made by the front
  typedef struct packed {
    logic    active;   // particle adds to the sum
    logic    last;     // closes the frame
    logic    divide;   // frame result needs sum / count
    status_t status;   // frame status before saturation, valid with last
  } ctl_t;

  typedef struct packed {
    ctl_t    ctl;
    coords_t pos;
    coords_t snap;
  } entry_t;

endpackage

FILE: sv/msd_if.sv
// ----------------------------------------------------------------------------
// msd_if
// Valid/ready stream interfaces for particle positions and frame results.
// ----------------------------------------------------------------------------
interface msd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               last;

  modport source (output valid, op, pos_x, pos_y, pos_z, last, input ready);
  modport sink   (input valid, op, pos_x, pos_y, pos_z, last, output ready);
endinterface

interface msd_out_if #(
  parameter int CNT_W = 11
);
  logic             valid;
  logic             ready;
  logic [63:0]      msd;
  logic [CNT_W-1:0] particle_count;
  logic [2:0]       status;

  modport source (output valid, msd, particle_count, status, input ready);
  modport sink   (input valid, msd, particle_count, status, output ready);
endinterface

FILE: sv/mean_squared_displacement.sv
// ----------------------------------------------------------------------------
// mean_squared_displacement
// Streams frames of particle positions, keeps a reference snapshot and
// reports the mean squared displacement of each frame against it.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Payload
//  --------  ---  ---------------  ---------------------------------------
//  items     in   valid / ready    op, pos_x, pos_y, pos_z, last
//  results   out  valid / ready    msd, particle_count, status
//  cfg       in   cfg_we only      cfg_index, cfg_data
//
//  The front takes one particle per cycle while the queue has room.
//  Each frame end waits for the pipeline to drain, plus the bit-serial
//  divider when a mean is computed; meanwhile the queue fills and then
//  holds items off.
//  A held result lets the next frame run until that frame's result is due.
//  Reset is synchronous; the snapshot memory is not cleared, and a
//  measurement without a committed snapshot is reported as such.
//
module mean_squared_displacement #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  msd_in_if.sink                              items,
  msd_out_if.source                           results,
  input  logic                                cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import msd_pkg::*;

  cfg_t   cfg;
  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   pop;
  entry_t head;
  logic   queue_empty;

  // Configuration registers. The user (not the block) ensures that writes
  // arrive only while it is idle, so the pipeline has stable values per frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WRAP_ENABLE: cfg.wrap_enable <= cfg_data[0];
        REG_BOX_X:       cfg.box_x       <= cfg_data[BOX_W-1:0];
        REG_BOX_Y:       cfg.box_y       <= cfg_data[BOX_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Front: accept, index, snapshot memory access and frame classification.
  msd_front #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  // Queue: lets the front keep taking particles while the back divides.
  msd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  // Back: displacement arithmetic, accumulation, division and result hold.
  msd_back #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .empty   (queue_empty),
    .pop     (pop),
    .results (results)
  );

endmodule

FILE: sv/msd_front.sv
// ----------------------------------------------------------------------------
// msd_front
// Accepts particles, tracks the slot index and snapshot bookkeeping, reads
// and writes the snapshot memory, and classifies each particle for the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msd_front #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  msd_in_if.sink            items,
  output logic              push,
  output msd_pkg::entry_t   push_entry,
  input  logic              queue_full
);
  import msd_pkg::*;

  localparam int IDX_W  = $clog2(MAX_PARTICLES + 2);
  localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
  localparam int ADDR_W = $clog2(MAX_PARTICLES);
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PARTICLES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

  logic [IDX_W-1:0]  index;
  logic [CNT_W-1:0]  ref_count;
  logic              ref_valid;

  coords_t           snap_mem [MAX_PARTICLES];
  coords_t           snap_rd;

  logic              f1_valid;
  ctl_t              f1_ctl;
  coords_t           f1_pos;

  logic              accept;
  logic              is_store;
  logic              is_measure;
  logic              in_range;
  logic [IDX_W-1:0]  index_inc;
  logic              over;
  logic [CNT_W-1:0]  frame_n;
  logic [ADDR_W-1:0] slot;
  ctl_t              ctl_next;
  coords_t           pos_in;

  assign items.ready = !f1_valid || !queue_full;
  assign accept      = items.valid && items.ready;
  assign push        = f1_valid && !queue_full;
  assign push_entry  = '{ctl: f1_ctl, pos: f1_pos, snap: snap_rd};

  assign pos_in = '{x: items.pos_x, y: items.pos_y, z: items.pos_z};
  assign slot   = index[ADDR_W-1:0];

  always_comb begin
    is_store   = (items.op == OP_SNAPSHOT) || (items.op == OP_MEASURE_SNAPSHOT);
    is_measure = (items.op != OP_SNAPSHOT);
    in_range   = index < MAX_IDX;
    index_inc  = (index <= MAX_IDX) ? index + 1'b1 : index;
    over       = index_inc > MAX_IDX;
    frame_n    = over ? MAX_CNT : index_inc[CNT_W-1:0];

    ctl_next.active = in_range && is_measure && ref_valid && (index < IDX_W'(ref_count));
    ctl_next.last   = items.last;
    ctl_next.divide = is_measure && ref_valid && !over && (frame_n == ref_count);
    priority if (is_measure && !ref_valid) begin
      ctl_next.status = ST_NO_SNAPSHOT;
    end else if (over) begin
      ctl_next.status = ST_CAPACITY;
    end else if (is_measure && (frame_n != ref_count)) begin
      ctl_next.status = ST_MISMATCH;
    end else begin
      ctl_next.status = ST_OK;
    end
  end

  // snapshot memory: read old data at the slot, then overwrite when storing
  always_ff @(posedge clk) begin
    if (accept) begin
      snap_rd <= snap_mem[slot];
      if (in_range && is_store) begin
        snap_mem[slot] <= pos_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_ctl <= ctl_next;
      f1_pos <= pos_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      index     <= '0;
      ref_count <= '0;
      ref_valid <= 1'b0;
    end else begin
      if (accept) begin
        f1_valid <= 1'b1;
      end else if (push) begin
        f1_valid <= 1'b0;
      end
      if (accept) begin
        index <= items.last ? '0 : index_inc;
        if (items.last && is_store) begin
          ref_count <= frame_n;
          ref_valid <= !over;
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_index_bound, clk, rst, index <= MAX_IDX + 1'b1,
    "slot index ran past capacity plus one")
  `ASSERT_IMPLY(a_snap_count, clk, rst, ref_valid,
    (ref_count != '0) && (ref_count <= MAX_CNT), "valid snapshot with bad count")
  `ASSERT_NEXT(a_frame_restart, clk, rst, accept && items.last, index == '0,
    "index not cleared after frame end")

endmodule

FILE: sv/msd_fifo.sv
// ----------------------------------------------------------------------------
// msd_fifo
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module msd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  msd_pkg::entry_t push_entry,
  input  logic            pop,
  output msd_pkg::entry_t head,
  output logic            full,
  output logic            empty
);
  import msd_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head  = slots[rd_ptr];
  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/msd_back.sv
// ----------------------------------------------------------------------------
// msd_back
// Displacement pipeline (difference, wrap, square, add, accumulate), frame
// count, bit-serial divider and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msd_back #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  msd_pkg::cfg_t   cfg,
  input  msd_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  msd_out_if.source       results
);
  import msd_pkg::*;

  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

  back_state_t          state;
  back_state_t          state_next;
  logic                 start;
  logic                 div_step;
  logic                 load_out;
  logic                 frame_busy;

  logic                 s1_valid;
  entry_t               s1;
  logic                 s2_valid;
  ctl_t                 s2_ctl;
  logic [POS_W-1:0]     s2_ax, s2_ay, s2_az;
  logic                 s3_valid;
  ctl_t                 s3_ctl;
  logic [POS_W-1:0]     s3_ax, s3_ay, s3_az;
  logic                 s4_valid;
  ctl_t                 s4_ctl;
  logic [2*POS_W-1:0]   s4_sqx, s4_sqy, s4_sqz;
  logic                 s5_valid;
  ctl_t                 s5_ctl;
  logic [MSD_W+1:0]     s5_psum;

  logic [MSD_W-1:0]     sum;
  logic                 sat;
  logic [CNT_W-1:0]     cnt;
  logic [MSD_W+2:0]     sum_total;
  logic                 ovf;
  logic [MSD_W-1:0]     sum_new;
  logic                 sat_new;
  logic [CNT_W-1:0]     cnt_new;

  logic [MSD_W-1:0]     quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     div_n;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W:0]       rem_shift;
  logic                 rem_ge;
  status_t              res_status;

  logic                 out_valid;
  logic [MSD_W-1:0]     out_msd;
  logic [CNT_W-1:0]     out_count;
  status_t              out_status;

  function automatic logic [POS_W-1:0] axis_mag(input logic [POS_W-1:0] p,
                                               input logic [POS_W-1:0] r);
    logic [POS_W:0] d_pr;
    logic [POS_W:0] d_rp;
    d_pr = {p[POS_W-1], p} - {r[POS_W-1], r};
    d_rp = {r[POS_W-1], r} - {p[POS_W-1], p};
    return d_pr[POS_W] ? d_rp[POS_W-1:0] : d_pr[POS_W-1:0];
  endfunction

  // fold a displacement over half the box into |box - |d||
  function automatic logic [POS_W-1:0] wrap_fold(input logic [POS_W-1:0] a,
                                                input logic [BOX_W-1:0] box,
                                                input logic             en);
    logic [POS_W:0] b_minus_a;
    logic [POS_W:0] a_minus_b;
    logic           over_half;
    over_half = {a, 1'b0} > {2'b00, box};
    b_minus_a = {2'b00, box} - {1'b0, a};
    a_minus_b = {1'b0, a} - {2'b00, box};
    if (en && over_half) begin
      return b_minus_a[POS_W] ? a_minus_b[POS_W-1:0] : b_minus_a[POS_W-1:0];
    end
    return a;
  endfunction

  assign pop = !empty && !frame_busy;

  // ---- displacement pipeline, never stalls ----
  always_ff @(posedge clk) begin
    if (pop) begin
      s1 <= head;
    end
    s2_ctl <= s1.ctl;
    s2_ax  <= axis_mag(s1.pos.x, s1.snap.x);
    s2_ay  <= axis_mag(s1.pos.y, s1.snap.y);
    s2_az  <= axis_mag(s1.pos.z, s1.snap.z);
    s3_ctl <= s2_ctl;
    s3_ax  <= wrap_fold(s2_ax, cfg.box_x, cfg.wrap_enable);
    s3_ay  <= wrap_fold(s2_ay, cfg.box_y, cfg.wrap_enable);
    s3_az  <= s2_az;
    s4_ctl <= s3_ctl;
    s4_sqx <= s3_ax * s3_ax;
    s4_sqy <= s3_ay * s3_ay;
    s4_sqz <= s3_az * s3_az;
    s5_ctl <= s4_ctl;
    s5_psum <= s4_ctl.active
             ? {2'b00, s4_sqx} + {2'b00, s4_sqy} + {2'b00, s4_sqz}
             : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s1_valid <= pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // ---- saturating accumulator and frame count ----
  always_comb begin
    sum_total = {3'b000, sum} + {1'b0, s5_psum};
    ovf       = |sum_total[MSD_W+2:MSD_W];
    sum_new   = ovf ? '1 : sum_total[MSD_W-1:0];
    sat_new   = sat || ovf;
    cnt_new   = (cnt == MAX_CNT) ? cnt : cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      sat <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      sum <= '0;
      sat <= 1'b0;
      cnt <= '0;
    end else if (s5_valid) begin
      sum <= sum_new;
      sat <= sat_new;
      cnt <= cnt_new;
    end
  end

  // ---- frame-end sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    start      = 1'b0;
    div_step   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_RUN: begin
        if (s5_valid && s5_ctl.last) begin
          start      = 1'b1;
          state_next = s5_ctl.divide ? BK_DIVIDE : BK_DELIVER;
        end
      end
      BK_DIVIDE: begin
        div_step = 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = BK_DELIVER;
        end
      end
      BK_DELIVER: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = BK_RUN;
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
  end

  // ---- restoring divider: one quotient bit per cycle ----
  assign rem_shift = {rem, quo[MSD_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_n};

  always_ff @(posedge clk) begin
    if (start) begin
      quo        <= s5_ctl.divide ? sum_new : '0;
      rem        <= '0;
      div_n      <= cnt_new;
      div_cnt    <= '0;
      res_status <= (s5_ctl.divide && sat_new) ? ST_SATURATED : s5_ctl.status;
    end else if (div_step) begin
      quo     <= {quo[MSD_W-2:0], rem_ge};
      rem     <= rem_ge ? CNT_W'(rem_shift - {1'b0, div_n}) : rem_shift[CNT_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_busy <= 1'b0;
    end else if (pop && head.ctl.last) begin
      frame_busy <= 1'b1;
    end else if (load_out) begin
      frame_busy <= 1'b0;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_msd    <= quo;
      out_count  <= div_n;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid          = out_valid;
  assign results.msd            = out_msd;
  assign results.particle_count = out_count;
  assign results.status         = out_status;

  `ASSERT_IMPLY(a_drained, clk, rst, state != BK_RUN,
    !(s1_valid || s2_valid || s3_valid || s4_valid || s5_valid),
    "pipeline busy while the frame result is pending")
  `ASSERT_IMPLY(a_rem_bound, clk, rst, state == BK_DIVIDE, rem < div_n,
    "divider remainder not below divisor")
  `ASSERT_IMPLY(a_sat_sum, clk, rst, sat, sum == '1,
    "saturation flag set without saturated sum")

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Mean squared displacement testbench
// Streams frames of particle positions into the block with random valid and
// ready gaps, predicts every frame result in a scoreboard class and compares
// the results field by field. Directed frames cover extremes, every op code,
// saturation, wrap, count mismatch and missing snapshot; random phases sweep
// the box and wrap registers and include a frame past the particle capacity.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  localparam int unsigned MAX_PART      = 1024;
  localparam int unsigned CNT_W         = 11;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  // pipeline drain plus the 64-step divider, with margin
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS   = 90;
  localparam int unsigned PHASES        = 8;

  // op code outside the enum; the block treats it as measure only
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] ONE     = 32'sh0001_0000;
  localparam logic [30:0]        BOX_MAX = 31'h7fff_ffff;

  typedef struct {
    logic [63:0]      msd;
    logic [CNT_W-1:0] count;
    status_t          status;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the snapshot memory, the running sum and the
  // register file, and keeps the frame results still owed by the block.
  // --------------------------------------------------------------------------
  class displacement_scoreboard;
    logic signed [31:0] snap_x [MAX_PART];
    logic signed [31:0] snap_y [MAX_PART];
    logic signed [31:0] snap_z [MAX_PART];
    bit                 written [MAX_PART];
    logic [63:0]        sum_sq;
    int unsigned        slot_idx;
    int unsigned        snap_count;
    bit                 snap_valid;
    bit                 saturated;
    bit                 wrap;
    logic [30:0]        box_x;
    logic [30:0]        box_y;
    frame_result_t      frame_results [$];
    int unsigned        errors;

    function new();
      foreach (written[i]) written[i] = 1'b0;
      sum_sq     = '0;
      slot_idx   = 0;
      snap_count = 0;
      snap_valid = 1'b0;
      saturated  = 1'b0;
      wrap       = 1'b0;
      box_x      = '0;
      box_y      = '0;
      errors     = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_WRAP_ENABLE: wrap = value[0];
        REG_BOX_X:       box_x = value[30:0];
        REG_BOX_Y:       box_y = value[30:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return frame_results.size();
    endfunction

    // true when a measuring particle in the next slot would read a snapshot
    // entry that was never stored
    function bit blank_slot_ahead();
      return snap_valid && slot_idx < snap_count && slot_idx < MAX_PART &&
             !written[slot_idx];
    endfunction

    function logic [63:0] axis_distance(logic signed [31:0] p, logic signed [31:0] r,
                                        bit fold, logic [30:0] box);
      longint d;
      longint span;
      d = longint'(p) - longint'(r);
      if (d < 0) d = -d;
      if (fold && 2 * d > longint'({33'd0, box})) begin
        span = longint'({33'd0, box}) - d;
        d = (span < 0) ? -span : span;
      end
      return d;
    endfunction

    function void accumulate(logic [63:0] a);
      logic [64:0] total;
      total = {1'b0, sum_sq} + {1'b0, a * a};
      if (total[64]) begin
        sum_sq    = '1;
        saturated = 1'b1;
      end else begin
        sum_sq = total[63:0];
      end
    endfunction

    function void take_particle(logic [1:0] op, logic signed [31:0] px,
                                logic signed [31:0] py, logic signed [31:0] pz,
                                logic last);
      bit            measure;
      bit            store;
      bit            over;
      int unsigned   slot;
      int unsigned   n;
      frame_result_t res;
      measure = (op != OP_SNAPSHOT);
      store   = (op == OP_SNAPSHOT) || (op == OP_MEASURE_SNAPSHOT);
      slot    = slot_idx;
      if (slot < MAX_PART) begin
        if (measure && snap_valid && slot < snap_count) begin
          accumulate(axis_distance(px, snap_x[slot], wrap, box_x));
          accumulate(axis_distance(py, snap_y[slot], wrap, box_y));
          accumulate(axis_distance(pz, snap_z[slot], 1'b0, '0));
        end
        if (store) begin
          snap_x[slot]  = px;
          snap_y[slot]  = py;
          snap_z[slot]  = pz;
          written[slot] = 1'b1;
        end
      end
      if (slot_idx <= MAX_PART) slot_idx++;
      if (!last) return;

      over       = slot_idx > MAX_PART;
      n          = over ? MAX_PART : slot_idx;
      res.msd    = '0;
      res.status = ST_OK;
      if (measure) begin
        if (!snap_valid) res.status = ST_NO_SNAPSHOT;
        else if (over) res.status = ST_CAPACITY;
        else if (n != snap_count) res.status = ST_MISMATCH;
        else begin
          res.msd    = sum_sq / 64'(n);
          res.status = saturated ? ST_SATURATED : ST_OK;
        end
      end else if (over) begin
        res.status = ST_CAPACITY;
      end
      if (store) begin
        snap_count = n;
        snap_valid = !over;
      end
      res.count = CNT_W'(n);
      frame_results = {frame_results, res};
      sum_sq    = '0;
      saturated = 1'b0;
      slot_idx  = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function void check_frame(logic [63:0] msd, logic [CNT_W-1:0] count,
                              logic [2:0] status);
      frame_result_t want;
      if (frame_results.size() == 0) begin
        report($sformatf("unexpected result msd=%h count=%0d status=%0d",
                         msd, count, status));
        return;
      end
      want = frame_results.pop_front();
      if (msd !== want.msd)
        report($sformatf("msd: expected %h, got %h", want.msd, msd));
      if (count !== want.count)
        report($sformatf("particle_count: expected %0d, got %0d", want.count, count));
      if (status !== want.status)
        report($sformatf("status: expected %0d, got %0d", want.status, status));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, interfaces and the block
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  always #4 clk = ~clk;

  msd_in_if                   items_if ();
  msd_out_if #(.CNT_W(CNT_W)) results_if ();

  mean_squared_displacement #(
    .MAX_PARTICLES(MAX_PART)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .items    (items_if),
    .results  (results_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  displacement_scoreboard sb;
  bit                     calm;        // no idling on either side
  int unsigned            cycle_count = 0;

  // Pick an idle stretch: mostly none, some short, a few long.
  function int unsigned idle_length();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  // Pick one coordinate: mostly a small step off the stored snapshot so that
  // sums stay in range and wrap decisions fall on both sides, else noise or
  // an extreme.
  function logic signed [31:0] pick_coord(int unsigned slot, int axis);
    logic signed [31:0] base;
    logic signed [31:0] step;
    int unsigned        mode;
    if (slot < MAX_PART && sb.written[slot])
      base = (axis == 0) ? sb.snap_x[slot] : (axis == 1) ? sb.snap_y[slot] : sb.snap_z[slot];
    else
      base = $urandom;
    mode = $urandom_range(0, 9);
    if (mode == 0) return $urandom;
    if (mode == 1) begin
      case ($urandom_range(0, 2))
        0:       return POS_MIN;
        1:       return POS_MAX;
        default: return '0;
      endcase
    end
    step = $signed($urandom) >>> $urandom_range(2, 28);
    return base + step;
  endfunction

  // Timeout watchdog: abort a run that stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: check each transaction, then choose next cycle's ready.
  // Values read here are the ones before this edge's updates.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_if.valid && results_if.ready)
        sb.check_frame(results_if.msd, results_if.particle_count, results_if.status);
      if (stall_left > 0) begin
        results_if.ready <= 1'b0;
        stall_left--;
      end else begin
        results_if.ready <= 1'b1;
        stall_left = idle_length();
      end
    end
  end

  // Present one particle after an optional gap and hold it until accepted.
  // Keep valid high across back-to-back transactions.
  task automatic send_particle(logic [1:0] op, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z,
                               logic last);
    int unsigned gap;
    gap = idle_length();
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.op    <= op;
    items_if.pos_x <= x;
    items_if.pos_y <= y;
    items_if.pos_z <= z;
    items_if.last  <= last;
    do @(posedge clk); while (!items_if.ready);
    sb.take_particle(op, x, y, z, last);
  endtask

  // Send a whole frame; in a mixed frame each particle draws its own op.
  // Demote a measuring particle to snapshot if it would hit a blank slot.
  task automatic send_frame(logic [1:0] kind, int unsigned n, bit mixed);
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    for (int unsigned i = 0; i < n; i++) begin
      op = mixed ? 2'($urandom_range(0, 3)) : kind;
      if (op != OP_SNAPSHOT && sb.blank_slot_ahead()) op = OP_SNAPSHOT;
      x = pick_coord(sb.slot_idx, 0);
      y = pick_coord(sb.slot_idx, 1);
      z = pick_coord(sb.slot_idx, 2);
      send_particle(op, x, y, z, i == n - 1);
    end
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic drain_idle();
    items_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; write enable stays high
  // across them and drops after the last.
  task automatic set_config(logic wrap, logic [30:0] bx, logic [30:0] by);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WRAP_ENABLE;
    cfg_data  <= CFG_DATA_W'(wrap);
    @(posedge clk);
    sb.write_reg(REG_WRAP_ENABLE, CFG_DATA_W'(wrap));
    cfg_index <= REG_BOX_X;
    cfg_data  <= bx;
    @(posedge clk);
    sb.write_reg(REG_BOX_X, bx);
    cfg_index <= REG_BOX_Y;
    cfg_data  <= by;
    @(posedge clk);
    sb.write_reg(REG_BOX_Y, by);
    cfg_we <= 1'b0;
  endtask

  function int unsigned pick_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(9, 48);
    return $urandom_range(1, 8);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_items;
    int unsigned cur_n;
    int unsigned n;
    int unsigned r;
    logic        wrap;
    logic [30:0] bx;
    logic [30:0] by;

    sb = new();
    calm = 1'b0;
    rst            <= 1'b1;
    items_if.valid <= 1'b0;
    items_if.op    <= OP_SNAPSHOT;
    items_if.pos_x <= '0;
    items_if.pos_y <= '0;
    items_if.pos_z <= '0;
    items_if.last  <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_WRAP_ENABLE;
    cfg_data       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed frames with registers at their reset values.
    // Measure before any snapshot exists.
    send_particle(OP_MEASURE, ONE, -ONE, 3 * ONE, 1'b0);
    send_particle(OP_MEASURE, ONE, -ONE, 3 * ONE, 1'b1);
    // Snapshot at the most negative position on every axis.
    send_particle(OP_SNAPSHOT, POS_MIN, POS_MIN, POS_MIN, 1'b0);
    send_particle(OP_SNAPSHOT, POS_MIN, POS_MIN, POS_MIN, 1'b1);
    // Full-scale displacement on all axes saturates the sum.
    send_particle(OP_MEASURE, POS_MAX, POS_MAX, POS_MAX, 1'b0);
    send_particle(OP_MEASURE, POS_MAX, POS_MAX, POS_MAX, 1'b1);
    // Frame longer than the snapshot, then shorter.
    send_particle(OP_MEASURE, '0, ONE, '0, 1'b0);
    send_particle(OP_MEASURE, '0, ONE, '0, 1'b0);
    send_particle(OP_MEASURE, '0, ONE, '0, 1'b1);
    send_particle(OP_MEASURE, ONE, '0, '0, 1'b1);
    // Measure then replace the snapshot with the origin.
    send_particle(OP_MEASURE_SNAPSHOT, '0, '0, '0, 1'b0);
    send_particle(OP_MEASURE_SNAPSHOT, '0, '0, '0, 1'b1);
    // Spare op code measures only.
    send_particle(OP_SPARE, ONE, -ONE, 3 * ONE, 1'b0);
    send_particle(OP_SPARE, -(2 * ONE), ONE + 1, -1, 1'b1);
    // Mixed frame: the snapshot op on the last particle sets the frame kind.
    send_particle(OP_MEASURE, 5 * ONE, ONE, '0, 1'b0);
    send_particle(OP_SNAPSHOT, '0, '0, '0, 1'b1);
    drain_idle();

    // Wrap on a small x box and the widest y box.
    set_config(1'b1, 31'(10 * ONE), BOX_MAX);
    send_particle(OP_SNAPSHOT, '0, '0, '0, 1'b0);
    send_particle(OP_SNAPSHOT, '0, '0, '0, 1'b0);
    send_particle(OP_SNAPSHOT, '0, '0, '0, 1'b1);
    // x over half the box folds, x at exactly half does not; y at positive
    // full scale folds to zero.
    send_particle(OP_MEASURE, 6 * ONE, POS_MAX, ONE, 1'b0);
    send_particle(OP_MEASURE, -(9 * ONE), POS_MIN, -ONE, 1'b0);
    send_particle(OP_MEASURE, 5 * ONE, -(3 * ONE), 7, 1'b1);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_idle();
      calm = (ph == 2);
      case (ph)
        0: begin
          wrap = 1'b0;
          bx   = '0;
          by   = '0;
        end
        1: begin
          wrap = 1'b1;
          bx   = BOX_MAX;
          by   = BOX_MAX;
        end
        2: begin
          wrap = 1'b1;
          bx   = '0;
          by   = '0;
        end
        default: begin
          wrap = (ph == 3) ? 1'b1 : 1'($urandom_range(0, 1));
          bx   = $urandom_range(0, 1) ? 31'($urandom_range(ONE, 64 * ONE)) : 31'($urandom);
          by   = $urandom_range(0, 1) ? 31'($urandom_range(ONE, 64 * ONE)) : 31'($urandom);
        end
      endcase
      set_config(wrap, bx, by);

      if (ph == 3) begin
        // Overflow a measuring frame against a valid snapshot; its commit
        // also drops the snapshot. Then rebuild and measure a short one.
        send_frame(OP_MEASURE_SNAPSHOT, MAX_PART + 1, 1'b0);
        send_frame(OP_SNAPSHOT, 4, 1'b0);
        send_frame(OP_MEASURE, 4, 1'b0);
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        cur_n = sb.snap_valid ? sb.snap_count : $urandom_range(1, 8);
        r = $urandom_range(0, 99);
        if (r < 15) begin
          n = pick_size();
          send_frame(OP_SNAPSHOT, n, 1'b0);
        end else if (r < 45) begin
          n = cur_n;
          send_frame(OP_MEASURE, n, 1'b0);
        end else if (r < 68) begin
          n = cur_n;
          send_frame(OP_MEASURE_SNAPSHOT, n, 1'b0);
        end else if (r < 78) begin
          // off-by-one frame length
          n = ($urandom_range(0, 1) || cur_n == 1) ? cur_n + 1 : cur_n - 1;
          send_frame(OP_MEASURE, n, 1'b0);
        end else if (r < 86) begin
          n = cur_n;
          send_frame(OP_SPARE, n, 1'b0);
        end else begin
          n = cur_n;
          send_frame(OP_MEASURE, n, 1'b1);
        end
        phase_items += n;
      end
    end

    // Wait for the last results and a quiet stretch for stray ones.
    drain_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/msd_pkg.sv
sv/msd_if.sv
sv/msd_front.sv
sv/msd_fifo.sv
sv/msd_back.sv
sv/mean_squared_displacement.sv
verif/testbench.sv
